@@ hdl/rational_arithmetic_unit_assert.svh @@
// Assertion macros for the rational arithmetic unit checker.
// Clocked on i_clk, disabled while i_rst_n is low.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rau check failed");

// next-cycle implication
`define RAU_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rau check failed");

`endif

@@ hdl/rau_pkg.sv @@
// Shared constants, codes and controller/datapath structs of the rational unit.
// No dependencies.
`default_nettype none
package rau_pkg;
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_W = 33;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_MIX = 3'd4;

    localparam logic [1:0] OPD_AN = 2'd0;
    localparam logic [1:0] OPD_AD = 2'd1;
    localparam logic [1:0] OPD_BN = 2'd2;
    localparam logic [1:0] OPD_BD = 2'd3;

    localparam logic [1:0] DST_NUM = 2'd0;
    localparam logic [1:0] DST_DEN = 2'd1;
    localparam logic [1:0] DST_TMP = 2'd2;

    localparam logic [1:0] SRC_NUM = 2'd0;
    localparam logic [1:0] SRC_DEN = 2'd1;
    localparam logic [1:0] SRC_MIX = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_a;
        logic [1:0] mul_b;
        logic [1:0] mul_dst;
        logic       mul_neg;
        logic       comb;
        logic       gcd_init;
        logic       two_step;
        logic       gcd_step;
        logic       div_start;
        logic [1:0] div_src;
        logic       div_step;
        logic       div_wb;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic in_err;
        logic num_zero;
        logic x_odd;
        logic y_odd;
        logic xy_zero;
        logic out_full;
    } t_sts;
endpackage
`default_nettype wire

@@ hdl/rau_in_if.sv @@
// Input channel of the rational unit: two fractions and an operation kind.
// Width set by parameter W.
`default_nettype none
interface rau_in_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic [2:0]          kind;
    logic signed [W-1:0] a_numerator;
    logic signed [W-1:0] a_denominator;
    logic signed [W-1:0] b_numerator;
    logic signed [W-1:0] b_denominator;

    modport source (output valid, kind, a_numerator, a_denominator, b_numerator,
                    b_denominator, input ready);
    modport sink (input valid, kind, a_numerator, a_denominator, b_numerator,
                  b_denominator, output ready);
endinterface
`default_nettype wire

@@ hdl/rau_out_if.sv @@
// Output channel of the rational unit: reduced fraction or quotient/remainder.
// Uses rau_pkg for the result width.
`default_nettype none
interface rau_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [rau_pkg::RES_W-1:0]  result_numerator;
    logic signed [rau_pkg::RES_W-1:0]  result_denominator;
    logic                              divide_error;

    modport source (output valid, result_numerator, result_denominator, divide_error,
                    input ready);
    modport sink (input valid, result_numerator, result_denominator, divide_error,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/rau_ctrl.sv @@
// Sequencing state machine of the rational unit.
// Depends on rau_pkg; drives rau_dp through t_cmd, reads t_sts.
`default_nettype none
module rau_ctrl #(
    parameter int M = 2 * rau_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [2:0]    i_kind,
    input  wire rau_pkg::t_sts i_sts,
    output rau_pkg::t_cmd      o_cmd
);
    import rau_pkg::*;

    localparam int CW = $clog2(M);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_COMB = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_TWO  = 4'd6;
    localparam logic [3:0] S_GCD  = 4'd7;
    localparam logic [3:0] S_DVN  = 4'd8;
    localparam logic [3:0] S_LDD  = 4'd9;
    localparam logic [3:0] S_DVD  = 4'd10;
    localparam logic [3:0] S_MXS  = 4'd11;
    localparam logic [3:0] S_DVM  = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0]    r_state, n_state;
    logic [2:0]    r_kind, n_kind;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          last;

    assign last       = (r_cnt == CW'(M - 1));
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_kind     = i_kind;
                    if (i_sts.in_err) begin
                        n_state = S_DONE;
                    end else if (i_kind == KIND_MIX) begin
                        n_state = S_MXS;
                    end else begin
                        n_state = S_MUL0;
                    end
                end
            end
            S_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_a   = OPD_AN;
                o_cmd.mul_b   = (r_kind == KIND_MUL) ? OPD_BN : OPD_BD;
                o_cmd.mul_dst = DST_NUM;
                n_state       = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_a   = OPD_AD;
                o_cmd.mul_b   = (r_kind == KIND_DIV) ? OPD_BN : OPD_BD;
                o_cmd.mul_dst = DST_DEN;
                n_state = (r_kind == KIND_ADD || r_kind == KIND_SUB) ? S_MUL2 : S_CHK;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_a   = OPD_AD;
                o_cmd.mul_b   = OPD_BN;
                o_cmd.mul_dst = DST_TMP;
                o_cmd.mul_neg = (r_kind == KIND_SUB);
                n_state       = S_COMB;
            end
            S_COMB: begin
                o_cmd.comb = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (i_sts.num_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    n_state        = S_TWO;
                end
            end
            S_TWO: begin
                if (i_sts.x_odd || i_sts.y_odd) begin
                    n_state = S_GCD;
                end else begin
                    o_cmd.two_step = 1'b1;
                end
            end
            S_GCD: begin
                if (i_sts.xy_zero) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = SRC_NUM;
                    n_cnt           = '0;
                    n_state         = S_DVN;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DVN: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_src  = SRC_NUM;
                n_cnt          = r_cnt + 1'b1;
                if (last) begin
                    o_cmd.div_wb = 1'b1;
                    n_state      = S_LDD;
                end
            end
            S_LDD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_src   = SRC_DEN;
                n_cnt           = '0;
                n_state         = S_DVD;
            end
            S_DVD: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_src  = SRC_DEN;
                n_cnt          = r_cnt + 1'b1;
                if (last) begin
                    o_cmd.div_wb = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_MXS: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_src   = SRC_MIX;
                n_cnt           = '0;
                n_state         = S_DVM;
            end
            S_DVM: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_src  = SRC_MIX;
                n_cnt          = r_cnt + 1'b1;
                if (last) begin
                    o_cmd.div_wb = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_ADD;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_cnt   <= n_cnt;
        end
    end
endmodule
`default_nettype wire

@@ hdl/rau_dp.sv @@
// Datapath of the rational unit: operand registers, shared multiplier, binary
// gcd, restoring divider and output register. Depends on rau_pkg.
`default_nettype none
module rau_dp #(
    parameter int W = rau_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire rau_pkg::t_cmd               i_cmd,
    output rau_pkg::t_sts                    o_sts,
    input  wire logic [2:0]                  i_kind,
    input  wire logic [W-1:0]                i_an,
    input  wire logic [W-1:0]                i_ad,
    input  wire logic [W-1:0]                i_bn,
    input  wire logic [W-1:0]                i_bd,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic signed [rau_pkg::RES_W-1:0] o_num,
    output logic signed [rau_pkg::RES_W-1:0] o_den,
    output logic                             o_err
);
    import rau_pkg::*;

    localparam int M   = 2 * W;
    localparam int EXT = (M > RES_W) ? M : RES_W;

    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic         r_san, r_sad, r_sbn, r_sbd;
    logic         r_err;
    logic [M-1:0] r_num, r_den, r_tmp;
    logic         r_num_neg, r_den_neg, r_tmp_neg;
    logic [M-1:0] r_x, r_y;
    logic [M-1:0] r_dq, r_rem, r_dv;
    logic         r_ovalid;
    logic signed [RES_W-1:0] r_onum, r_oden;
    logic         r_oerr;

    logic         in_err;
    logic [W-1:0] ma, mb;
    logic         sa, sb;
    logic [M-1:0] prod;
    logic         psgn;
    logic [M-1:0] sum_mag;
    logic         sum_neg;
    logic [M:0]   rem_sh, diff;
    logic         ge;
    logic [M-1:0] rem_nx, q_nx;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        f_mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [RES_W-1:0] f_out(input logic [M-1:0] mag, input logic neg);
        logic [EXT-1:0]   ext;
        logic [RES_W-1:0] m;
        ext   = EXT'(mag);
        m     = ext[RES_W-1:0];
        f_out = neg ? (~m + 1'b1) : m;
    endfunction

    assign in_err = (i_kind > KIND_MIX) || (i_ad == '0)
                    || ((i_kind < KIND_MIX) && (i_bd == '0))
                    || ((i_kind == KIND_DIV) && (i_bn == '0));

    always_comb begin
        case (i_cmd.mul_a)
            OPD_AN:  begin ma = r_an; sa = r_san; end
            OPD_AD:  begin ma = r_ad; sa = r_sad; end
            OPD_BN:  begin ma = r_bn; sa = r_sbn; end
            default: begin ma = r_bd; sa = r_sbd; end
        endcase
        case (i_cmd.mul_b)
            OPD_AN:  begin mb = r_an; sb = r_san; end
            OPD_AD:  begin mb = r_ad; sb = r_sad; end
            OPD_BN:  begin mb = r_bn; sb = r_sbn; end
            default: begin mb = r_bd; sb = r_sbd; end
        endcase
    end

    assign prod = M'(ma) * M'(mb);
    assign psgn = (sa ^ sb ^ i_cmd.mul_neg) && (prod != '0);

    always_comb begin
        if (r_num_neg == r_tmp_neg) begin
            sum_mag = r_num + r_tmp;
            sum_neg = r_num_neg;
        end else if (r_num >= r_tmp) begin
            sum_mag = r_num - r_tmp;
            sum_neg = r_num_neg;
        end else begin
            sum_mag = r_tmp - r_num;
            sum_neg = r_tmp_neg;
        end
        if (sum_mag == '0) begin
            sum_neg = 1'b0;
        end
    end

    assign rem_sh = {r_rem, r_dq[M-1]};
    assign diff   = rem_sh - {1'b0, r_dv};
    assign ge     = !diff[M];
    assign rem_nx = ge ? diff[M-1:0] : rem_sh[M-1:0];
    assign q_nx   = {r_dq[M-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_an  <= f_mag(i_an);
            r_ad  <= f_mag(i_ad);
            r_bn  <= f_mag(i_bn);
            r_bd  <= f_mag(i_bd);
            r_san <= i_an[W-1];
            r_sad <= i_ad[W-1];
            r_sbn <= i_bn[W-1];
            r_sbd <= i_bd[W-1];
            r_err <= in_err;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_dst)
                DST_NUM: begin r_num <= prod; r_num_neg <= psgn; end
                DST_DEN: begin r_den <= prod; r_den_neg <= psgn; end
                default: begin r_tmp <= prod; r_tmp_neg <= psgn; end
            endcase
        end
        if (i_cmd.comb) begin
            r_num     <= sum_mag;
            r_num_neg <= sum_neg;
        end
        if (i_cmd.gcd_init) begin
            r_x <= r_num;
            r_y <= r_den;
        end
        if (i_cmd.two_step) begin
            r_x   <= r_x >> 1;
            r_y   <= r_y >> 1;
            r_num <= r_num >> 1;
            r_den <= r_den >> 1;
        end
        if (i_cmd.gcd_step) begin
            if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x >= r_y) begin
                r_x <= r_x - r_y;
            end else begin
                r_y <= r_y - r_x;
            end
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            case (i_cmd.div_src)
                SRC_NUM: begin r_dq <= r_num;     r_dv <= r_x | r_y; end
                SRC_DEN: begin r_dq <= r_den;     r_dv <= r_x | r_y; end
                default: begin r_dq <= M'(r_an);  r_dv <= M'(r_ad);  end
            endcase
        end
        if (i_cmd.div_step) begin
            r_dq  <= q_nx;
            r_rem <= rem_nx;
        end
        if (i_cmd.div_wb) begin
            case (i_cmd.div_src)
                SRC_NUM: r_num <= q_nx;
                SRC_DEN: r_den <= q_nx;
                default: begin
                    r_num     <= q_nx;
                    r_num_neg <= (r_san ^ r_sad) && (q_nx != '0);
                    r_den     <= rem_nx;
                    r_den_neg <= r_san && (rem_nx != '0);
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_oerr <= r_err;
            r_onum <= r_err ? '0 : f_out(r_num, r_num_neg);
            r_oden <= r_err ? '0 : f_out(r_den, r_den_neg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_sts.in_err   = in_err;
    assign o_sts.num_zero = (r_num == '0);
    assign o_sts.x_odd    = r_x[0];
    assign o_sts.y_odd    = r_y[0];
    assign o_sts.xy_zero  = (r_x == '0) || (r_y == '0);
    assign o_sts.out_full = r_ovalid && !i_ready;

    assign o_valid = r_ovalid;
    assign o_num   = r_onum;
    assign o_den   = r_oden;
    assign o_err   = r_oerr;
endmodule
`default_nettype wire

@@ hdl/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: add, subtract, multiply, divide of two fractions
// with gcd reduction, or mixed conversion of the first fraction.
// Depends on rau_pkg, rau_in_if, rau_out_if, rau_ctrl and rau_dp.
//
// i_in takes one word per item: kind and two fractions a, b of OPERAND_WIDTH
// bits. o_out gives one word per item: numerator, denominator (or quotient,
// remainder for mixed conversion) and divide_error.
// An item is taken only while the controller is idle; one item at a time.
// Steps per item, with M = 2*OPERAND_WIDTH:
//   error item        : straight to the output load
//   mixed conversion  : an M-bit divide of a's numerator by its denominator
//   zero numerator    : the products, then straight to the output load
//   other kinds       : the products, then the gcd loop, which takes one
//                       shift or subtract per cycle, then divides by the gcd.
// The gcd loop and the bit-serial divider, one quotient bit per cycle, do
// most work. A finished word sits in the output register; the next item is
// taken and worked on while it waits, and only the final load holds off
// until the receiver takes the word.
// Reset clears the controller and the output valid; no clearing pass.
`default_nettype none
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    rau_in_if.sink   i_in,
    rau_out_if.source o_out
);
    import rau_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rau_ctrl #(.M(2 * OPERAND_WIDTH)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_kind     (i_in.kind),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rau_dp #(.W(OPERAND_WIDTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_kind  (i_in.kind),
        .i_an    (i_in.a_numerator),
        .i_ad    (i_in.a_denominator),
        .i_bn    (i_in.b_numerator),
        .i_bd    (i_in.b_denominator),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_num   (o_out.result_numerator),
        .o_den   (o_out.result_denominator),
        .o_err   (o_out.divide_error)
    );
endmodule
`default_nettype wire

@@ hdl/rau_chk.sv @@
// Port-level checker of the rational unit, bound to the top level.
// Depends on rau_pkg and rational_arithmetic_unit_assert.svh.
`default_nettype none
`include "rational_arithmetic_unit_assert.svh"
module rau_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             i_in_ready,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [rau_pkg::RES_W-1:0]        i_num,
    input wire logic [rau_pkg::RES_W-1:0]        i_den,
    input wire logic                             i_err
);
    `RAU_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_num) && $stable(i_den) && $stable(i_err))
    `RAU_IMPLY(a_err_zero, i_out_valid && i_err, i_num == '0 && i_den == '0)
    `RAU_NEXT(a_busy_after_take, i_in_valid && i_in_ready, !i_in_ready)
endmodule

bind rational_arithmetic_unit rau_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_num       (o_out.result_numerator),
    .i_den       (o_out.result_denominator),
    .i_err       (o_out.divide_error)
);
`default_nettype wire
